/* rtl/core/mck_pkg.sv */
// shared types, constants and code lookup for the morse character keyer
// no dependencies
`default_nettype none

package mck_pkg;

    localparam int CHAR_W   = 8;
    localparam int UNITS_W  = 4;
    localparam int DIT_W    = 16;
    localparam int DUR_W    = 20;
    localparam int CODE_W   = 8;
    localparam int CNT_W    = 3;

    localparam logic [DIT_W-1:0]   DIT_MS_RESET   = 16'd250;
    localparam logic [UNITS_W-1:0] GAP_RESET      = 4'd4;
    localparam logic [UNITS_W-1:0] BAD_UNITS      = 4'd15;
    localparam logic [UNITS_W-1:0] DASH_UNITS     = 4'd3;
    localparam logic [UNITS_W-1:0] DOT_UNITS      = 4'd1;
    localparam logic [UNITS_W-1:0] SPACE_UNITS    = 4'd1;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_AT    = 8'h40;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CH_Z     = 8'h5A;

    localparam int NUM_CODES = 28;
    localparam int IDX_SPACE = 26;
    localparam int IDX_AT    = 27;

    localparam logic [CODE_W-1:0] CODE_TABLE [NUM_CODES] = '{
        8'h05, 8'h18, 8'h1A, 8'h0C, 8'h02, 8'h12, 8'h0E, 8'h10, 8'h04, 8'h17,
        8'h0D, 8'h14, 8'h07, 8'h06, 8'h0F, 8'h16, 8'h1D, 8'h0A, 8'h08, 8'h03,
        8'h09, 8'h11, 8'h0B, 8'h19, 8'h1B, 8'h1C,
        8'h01,
        8'h5A
    };

    // register addresses
    localparam logic [2:0] ADDR_DIT_MS = 3'd0;
    localparam logic [2:0] ADDR_GAP    = 3'd4;

    typedef struct packed {
        logic                key_on;
        logic [UNITS_W-1:0]  units;
        logic                last;
    } t_seg;

    typedef struct packed {
        logic               known;
        logic [CODE_W-1:0]  code;
    } t_lookup;

    function automatic t_lookup code_of(input logic [CHAR_W-1:0] ch);
        t_lookup          res;
        logic [CHAR_W-1:0] off;
        off        = ch - CH_A;
        res.known  = 1'b1;
        res.code   = CODE_TABLE[IDX_SPACE];
        if (ch == CH_SPACE) begin
            res.code = CODE_TABLE[IDX_SPACE];
        end else if (ch == CH_AT) begin
            res.code = CODE_TABLE[IDX_AT];
        end else if (ch >= CH_A && ch <= CH_Z) begin
            res.code = CODE_TABLE[off[4:0]];
        end else begin
            res.known = 1'b0;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/mck_seq.sv */
// segment sequencer: shifts the code one element bit per dot/dash
// depends on mck_pkg
`default_nettype none

module mck_seq
    import mck_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic [CHAR_W-1:0]  i_character,
    input  wire logic [UNITS_W-1:0] i_gap_units,
    input  wire logic               i_take,
    output logic                    o_stall,
    output logic                    o_seg_valid,
    output t_seg                    o_seg
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ON   = 3'd1;
    localparam logic [2:0] ST_OFF  = 3'd2;
    localparam logic [2:0] ST_GAP  = 3'd3;
    localparam logic [2:0] ST_BAD  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [CODE_W-1:0] r_bits, n_bits;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    t_lookup           look;
    logic [CNT_W-1:0]  start_pos;
    logic [CODE_W-1:0] aligned;
    logic              accept;

    // start bit position and element bits moved to the top
    always_comb begin
        look      = code_of(i_character);
        start_pos = '0;
        for (int i = 0; i < CODE_W; i++) begin
            if (look.code[i]) begin
                start_pos = CNT_W'(i);
            end
        end
        aligned = CODE_W'(look.code << (4'd8 - {1'b0, start_pos}));
    end

    assign o_stall = (r_state != ST_IDLE);
    assign accept  = i_valid && (r_state == ST_IDLE);

    always_comb begin
        o_seg_valid = 1'b0;
        o_seg       = '{key_on: 1'b0, units: SPACE_UNITS, last: 1'b0};
        unique case (r_state)
            ST_IDLE: begin
                o_seg_valid = 1'b0;
            end
            ST_ON: begin
                o_seg_valid = 1'b1;
                o_seg       = '{key_on: 1'b1,
                                units: (r_bits[CODE_W-1] ? DASH_UNITS : DOT_UNITS),
                                last: 1'b0};
            end
            ST_OFF: begin
                o_seg_valid = 1'b1;
                o_seg       = '{key_on: 1'b0, units: SPACE_UNITS, last: 1'b0};
            end
            ST_GAP: begin
                o_seg_valid = 1'b1;
                o_seg       = '{key_on: 1'b0, units: i_gap_units, last: 1'b1};
            end
            ST_BAD: begin
                o_seg_valid = 1'b1;
                o_seg       = '{key_on: 1'b1, units: BAD_UNITS, last: 1'b1};
            end
            default: begin
                o_seg_valid = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_bits  = r_bits;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_bits = aligned;
                    n_cnt  = start_pos;
                    if (!look.known) begin
                        n_state = ST_BAD;
                    end else if (start_pos == '0) begin
                        n_state = ST_GAP;
                    end else begin
                        n_state = ST_ON;
                    end
                end
            end
            ST_ON: begin
                if (i_take) begin
                    n_state = ST_OFF;
                end
            end
            ST_OFF: begin
                if (i_take) begin
                    n_bits  = {r_bits[CODE_W-2:0], 1'b0};
                    n_cnt   = r_cnt - 1'b1;
                    n_state = (r_cnt == CNT_W'(1)) ? ST_GAP : ST_ON;
                end
            end
            ST_GAP, ST_BAD: begin
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_bits <= n_bits;
        r_cnt  <= n_cnt;
    end

endmodule

`default_nettype wire

/* rtl/core/mck_scale.sv */
// output stage: scales units by the dit length and holds the request
// depends on mck_pkg
`default_nettype none

module mck_scale
    import mck_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_seg_valid,
    input  wire t_seg               i_seg,
    input  wire logic [DIT_W-1:0]   i_dit_ms,
    input  wire logic               i_stall,
    output logic                    o_take,
    output logic                    o_valid,
    output logic                    o_key_on,
    output logic [UNITS_W-1:0]      o_units,
    output logic [DUR_W-1:0]        o_duration_ms,
    output logic                    o_last
);

    logic               r_valid;
    logic               r_key_on;
    logic [UNITS_W-1:0] r_units;
    logic [DUR_W-1:0]   r_dur;
    logic               r_last;
    logic [DUR_W-1:0]   n_dur;

    assign o_take = !r_valid || !i_stall;
    assign n_dur  = DUR_W'(DUR_W'(i_seg.units) * DUR_W'(i_dit_ms));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_seg_valid;
        end
        if (o_take && i_seg_valid) begin
            r_key_on <= i_seg.key_on;
            r_units  <= i_seg.units;
            r_dur    <= n_dur;
            r_last   <= i_seg.last;
        end
    end

    assign o_valid       = r_valid;
    assign o_key_on      = r_key_on;
    assign o_units       = r_units;
    assign o_duration_ms = r_dur;
    assign o_last        = r_last;

endmodule

`default_nettype wire

/* rtl/core/morse_character_keyer_top.sv */
// morse character keyer top: config registers, sequencer and output stage
// depends on mck_pkg, mck_seq, mck_scale
//
// channel   direction  handshake           payload
// input     in         i_valid / o_stall   i_character
// output    out        o_valid / i_stall   o_key_on, o_units, o_duration_ms, o_last
// config    in         apb psel/penable    paddr, pwdata, prdata
//
// take a character in idle, then one segment per cycle unless the output stalls
// a character gives 2 segments per element plus the gap, 13 for '@'
// the sequencer walks the code one element bit at a time through a shift register
// synchronous active-low reset clears state, dit_ms to 250 and gap to 4
// a stalled output holds the sequencer in place, input stays stalled until done
`default_nettype none

module morse_character_keyer_top
    import mck_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [CHAR_W-1:0]  i_character,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_key_on,
    output logic [UNITS_W-1:0]      o_units,
    output logic [DUR_W-1:0]        o_duration_ms,
    output logic                    o_last,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [DIT_W-1:0]   r_dit_ms;
    logic [UNITS_W-1:0] r_gap;
    logic               cfg_wr;
    logic               seg_valid;
    logic               take;
    t_seg               seg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dit_ms <= DIT_MS_RESET;
            r_gap    <= GAP_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == ADDR_DIT_MS[2]) begin
                r_dit_ms <= pwdata[DIT_W-1:0];
            end else begin
                r_gap <= pwdata[UNITS_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == ADDR_GAP[2]) begin
            prdata = {28'd0, r_gap};
        end else begin
            prdata = {16'd0, r_dit_ms};
        end
    end

    mck_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_character (i_character),
        .i_gap_units (r_gap),
        .i_take      (take),
        .o_stall     (o_stall),
        .o_seg_valid (seg_valid),
        .o_seg       (seg)
    );

    mck_scale u_scale (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_seg_valid   (seg_valid),
        .i_seg         (seg),
        .i_dit_ms      (r_dit_ms),
        .i_stall       (i_stall),
        .o_take        (take),
        .o_valid       (o_valid),
        .o_key_on      (o_key_on),
        .o_units       (o_units),
        .o_duration_ms (o_duration_ms),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

/* rtl/core/mck_checker.sv */
// port-level checks for the morse character keyer, bound to the top level
// depends on mck_pkg and morse_character_keyer_top
`default_nettype none

module mck_checker
    import mck_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_stall,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire logic               o_key_on,
    input wire logic [UNITS_W-1:0] o_units,
    input wire logic [DUR_W-1:0]   o_duration_ms,
    input wire logic               o_last
);

    // held request keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_units) && $stable(o_key_on)
            && $stable(o_last) && $stable(o_duration_ms))
        else $error("output request changed while stalled");

    // busy right after taking a character
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after accept");

    // fifteen-unit key-down only for an unknown character, always final
    a_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_key_on && o_units == BAD_UNITS |-> o_last)
        else $error("fifteen-unit key-down not final");

    // element on-segments are dots or dashes
    a_elem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_key_on && !o_last |-> (o_units == DOT_UNITS || o_units == DASH_UNITS))
        else $error("element length not dot or dash");

    // zero units means zero time
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_units == '0 |-> o_duration_ms == '0)
        else $error("zero units with nonzero duration");

endmodule

bind morse_character_keyer_top mck_checker u_mck_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_key_on      (o_key_on),
    .o_units       (o_units),
    .o_duration_ms (o_duration_ms),
    .o_last        (o_last)
);

`default_nettype wire

/* tb/tb_morse_character_keyer_top.sv */
`timescale 1ns / 100ps
// self-checking testbench for morse_character_keyer_top: characters in, key segments out
// predicts each segment of every character and checks the output stream in order
// depends on mck_pkg and morse_character_keyer_top

module tb_morse_character_keyer_top
    import mck_pkg::*;
();

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 30;

    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_AT    = 8'h40;
    localparam logic [7:0] CHR_A     = 8'h41;
    localparam logic [7:0] CHR_Z     = 8'h5A;
    localparam int SLOT_SPACE = 26;
    localparam int SLOT_AT    = 27;

    localparam logic [3:0] LEN_DASH    = 4'd3;
    localparam logic [3:0] LEN_DOT     = 4'd1;
    localparam logic [3:0] LEN_SPACE   = 4'd1;
    localparam logic [3:0] LEN_UNKNOWN = 4'd15;

    // codes behind a leading start bit, A..Z then space then @
    localparam logic [7:0] MORSE_CODES [28] = '{
        8'h05, 8'h18, 8'h1A, 8'h0C, 8'h02, 8'h12, 8'h0E, 8'h10, 8'h04, 8'h17,
        8'h0D, 8'h14, 8'h07, 8'h06, 8'h0F, 8'h16, 8'h1D, 8'h0A, 8'h08, 8'h03,
        8'h09, 8'h11, 8'h0B, 8'h19, 8'h1B, 8'h1C,
        8'h01,
        8'h5A
    };

    typedef struct packed {
        logic               key_on;
        logic [UNITS_W-1:0] units;
        logic [DUR_W-1:0]   duration_ms;
        logic               last;
    } t_key_seg;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [CHAR_W-1:0]  i_character = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_key_on;
    logic [UNITS_W-1:0] o_units;
    logic [DUR_W-1:0]   o_duration_ms;
    logic               o_last;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    t_key_seg    pending_segs[$];
    logic [15:0] cur_dit_ms = 16'd250;
    logic [3:0]  cur_gap_units = 4'd4;
    int          errors = 0;
    int          quiet_cycles = 0;
    bit          sender_idles = 1'b1;
    bit          receiver_idles = 1'b1;
    bit          hold_request = 1'b0;
    int          hold_left = 0;

    morse_character_keyer_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_character   (i_character),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_key_on      (o_key_on),
        .o_units       (o_units),
        .o_duration_ms (o_duration_ms),
        .o_last        (o_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void push_segment(input logic on, input logic [3:0] units,
                                         input logic last);
        t_key_seg    seg;
        logic [35:0] prod;
        prod            = units * cur_dit_ms;
        seg.key_on      = on;
        seg.units       = units;
        seg.duration_ms = prod[19:0];
        seg.last        = last;
        pending_segs.push_back(seg);
    endfunction

    function automatic void predict_key_segments(input logic [7:0] ch);
        logic [7:0] code;
        int         top;
        int         pos;
        if (ch == CHR_SPACE) begin
            code = MORSE_CODES[SLOT_SPACE];
        end else if (ch == CHR_AT) begin
            code = MORSE_CODES[SLOT_AT];
        end else if (ch >= CHR_A && ch <= CHR_Z) begin
            code = MORSE_CODES[ch - CHR_A];
        end else begin
            push_segment(1'b1, LEN_UNKNOWN, 1'b1);
            return;
        end
        top = 7;
        while (top >= 0 && !code[top]) top--;
        for (pos = top - 1; pos >= 0; pos--) begin
            push_segment(1'b1, code[pos] ? LEN_DASH : LEN_DOT, 1'b0);
            push_segment(1'b0, LEN_SPACE, 1'b0);
        end
        push_segment(1'b0, cur_gap_units, 1'b1);
    endfunction

    function automatic logic [7:0] random_character();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 68) return CHR_A + 8'($urandom_range(0, 25));
        if (pick < 78) return CHR_SPACE;
        if (pick < 84) return CHR_AT;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            errors++;
        end
    endtask

    // one character request, held until the block takes it
    task automatic send_char(input logic [7:0] ch);
        int gap;
        if (sender_idles && $urandom_range(0, 99) < 14) begin
            gap = $urandom_range(1, 16);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_character <= ch;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        predict_key_segments(ch);
    endtask

    task automatic wait_segments_drained();
        i_valid <= 1'b0;
        while (pending_segs.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_registers();
        logic [31:0] rd;
        apb_read(ADDR_DIT_MS, rd);
        check_field("dit_ms readback", cur_dit_ms, rd[15:0]);
        apb_read(ADDR_GAP, rd);
        check_field("char_gap_units readback", cur_gap_units, rd[3:0]);
    endtask

    // only called with nothing in flight; upper bits carry noise
    task automatic set_keyer(input logic [15:0] dit, input logic [3:0] gap);
        apb_write(ADDR_DIT_MS, {16'($urandom), dit});
        cur_dit_ms = dit;
        apb_write(ADDR_GAP, {28'($urandom), gap});
        cur_gap_units = gap;
        check_registers();
    endtask

    task automatic test_reset_defaults();
        check_registers();
        send_char("E");
        send_char("T");
        send_char(CHR_SPACE);
        wait_segments_drained();
    endtask

    task automatic test_character_classes();
        logic [7:0] chars [$];
        chars = '{8'h00, 8'hFF, CHR_AT, CHR_A, CHR_Z, 8'h3F, 8'h5B, 8'h61, 8'h7A,
                  8'h80, 8'h1F, "Q", "Y", "H", "O", CHR_SPACE};
        foreach (chars[i]) send_char(chars[i]);
        wait_segments_drained();
    endtask

    task automatic test_config_extremes();
        set_keyer(16'd1, 4'd0);
        send_char(CHR_SPACE);
        send_char("E");
        send_char(CHR_AT);
        send_char("a");
        wait_segments_drained();
        set_keyer(16'hFFFF, 4'd15);
        send_char(CHR_SPACE);
        send_char("Q");
        send_char(CHR_AT);
        send_char(8'hFF);
        wait_segments_drained();
        set_keyer(16'd0, 4'd7);
        send_char("B");
        send_char(CHR_SPACE);
        send_char("x");
        wait_segments_drained();
    endtask

    task automatic test_output_backpressure();
        set_keyer(16'd100, 4'd3);
        sender_idles = 1'b0;
        hold_request = 1'b1;
        repeat (16) send_char(random_character());
        wait_segments_drained();
        sender_idles = 1'b1;
    endtask

    task automatic test_random_traffic();
        int phase;
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_keyer(16'd250, 4'd4);
                1: set_keyer(16'hFFFF, 4'd15);
                2: set_keyer(16'd1, 4'd0);
                default: set_keyer(16'($urandom_range(1, 65535)), 4'($urandom_range(0, 15)));
            endcase
            // one phase runs with both sides flat out
            sender_idles   = (phase != 3);
            receiver_idles = (phase != 3);
            repeat (70) send_char(random_character());
            wait_segments_drained();
        end
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    always @(posedge i_clk) begin : seg_monitor
        t_key_seg want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_segs.size() == 0) begin
                $display("%0t: unexpected segment, expected none, %s%0d %s%0d %s%0d %s%0d",
                         $time, "actual key_on=", o_key_on, "units=", o_units,
                         "duration_ms=", o_duration_ms, "last=", o_last);
                errors++;
            end else begin
                want = pending_segs.pop_front();
                check_field("key_on", want.key_on, o_key_on);
                check_field("units", want.units, o_units);
                check_field("duration_ms", want.duration_ms, o_duration_ms);
                check_field("last", want.last, o_last);
            end
        end
        if (hold_request) begin
            hold_left    = HOLD_OFF_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= receiver_idles && ($urandom_range(0, 99) < 14);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_character_classes();
        test_config_extremes();
        test_output_backpressure();
        test_random_traffic();
        wait_segments_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
